/* design/slot_allocator_fifo_waitlist_defines.svh */
// Assertion macros shared by the slot allocator RTL.
// Included by the controller and the datapath; needs clk_i and rst_ni in scope.
`ifndef SLOT_ALLOCATOR_FIFO_WAITLIST_DEFINES_SVH
`define SLOT_ALLOCATOR_FIFO_WAITLIST_DEFINES_SVH

`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define SA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Condition that must never be true outside reset.
`define SA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define SA_ASSERT(lbl, prop, msg)
`define SA_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

/* design/salloc_pkg.sv */
// Shared types and constants of the slot allocator.
// No dependencies; imported by the controller, the datapath and the top level.
package salloc_pkg;

  localparam int DEF_SLOTS      = 16;
  localparam int DEF_REQUESTERS = 64;

  localparam int KIND_W   = 2;
  localparam int SIDX_W   = 4;
  localparam int ID_W     = 7;
  localparam int LOAD_W   = 14;
  localparam int STATUS_W = 3;
  localparam int COST_W   = 40;

  localparam int RATE_W   = 10;
  localparam int WEIGHT_W = 14;
  localparam int PROD_W   = RATE_W + WEIGHT_W;

  localparam int WAIT_DEPTH = 64;
  localparam int QUEUE_AW   = 6;
  localparam int COUNT_W    = 7;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_RATE   = 2'd0,
    KIND_LOAD_WEIGHT = 2'd1,
    KIND_ARRIVE      = 2'd2,
    KIND_DEPART      = 2'd3
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    RES_PLACED    = 3'd0,
    RES_QUEUED    = 3'd1,
    RES_FREED     = 3'd2,
    RES_PROMOTED  = 3'd3,
    RES_NOT_FOUND = 3'd4,
    RES_FULL      = 3'd5,
    RES_LOADED    = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_MUL,
    S_ACC
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic look_emit;
    logic acc_emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic dep_hit;
    logic out_room;
  } dp_stat_t;

endpackage

/* design/salloc_ctrl.sv */
// Sequencing controller of the slot allocator.
// Depends on salloc_pkg and the assertion macros header.
`include "slot_allocator_fifo_waitlist_defines.svh"

module salloc_ctrl import salloc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands. A departure that finds its slot takes the
  // multiply and accumulate states; everything else finishes in the lookup.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_LOOK;
        end
      end
      S_LOOK: begin
        if (stat_i.dep_hit) begin
          state_d = S_MUL;
        end else if (stat_i.out_room) begin
          cmd_o.look_emit = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_MUL: begin
        state_d = S_ACC;
      end
      S_ACC: begin
        if (stat_i.out_room) begin
          cmd_o.acc_emit = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Requests enter only while no other request is in flight.
  assign in_stall_o = (state_q != S_IDLE);

  `SA_ASSERT(a_accept_to_look, cmd_o.accept |=> state_q == S_LOOK, "accept did not start lookup")
  `SA_ASSERT(a_mul_to_acc, state_q == S_MUL |=> state_q == S_ACC, "multiply not followed by accumulate")
  `SA_ASSERT(a_emit_room, (cmd_o.look_emit || cmd_o.acc_emit) |-> stat_i.out_room, "result written without room")

endmodule

/* design/salloc_dp.sv */
// Datapath of the slot allocator: slot holders, rate and weight memories,
// wait queue, cost accumulator and result register. Depends on salloc_pkg.
`include "slot_allocator_fifo_waitlist_defines.svh"

module salloc_dp import salloc_pkg::*; #(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int REQUESTERS = DEF_REQUESTERS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ctrl_cmd_t           cmd_i,
  output dp_stat_t            stat_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [SIDX_W-1:0]   slot_index_i,
  input  logic [ID_W-1:0]     requester_id_i,
  input  logic [LOAD_W-1:0]   load_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SIDX_W-1:0]   slot_used_o,
  output logic [ID_W-1:0]     promoted_id_o,
  output logic [COST_W-1:0]   total_cost_o
);

  localparam int SlotW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int ReqW  = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;

  // Captured request.
  kind_e               kind_q;
  logic [SIDX_W-1:0]   sidx_q;
  logic [ID_W-1:0]     id_q;
  logic [LOAD_W-1:0]   val_q;

  // State.
  logic [ID_W-1:0]     holder_q [SLOTS];
  logic [RATE_W-1:0]   rate_mem [SLOTS];
  logic [WEIGHT_W-1:0] weight_mem [REQUESTERS];
  logic [ID_W-1:0]     queue_mem [WAIT_DEPTH];
  logic [QUEUE_AW-1:0] head_q, tail_q;
  logic [COUNT_W-1:0]  count_q;
  logic [COST_W-1:0]   cost_q;

  // Memory read data and pipeline registers.
  logic [RATE_W-1:0]   rate_rd_q;
  logic [WEIGHT_W-1:0] weight_rd_q;
  logic [ID_W-1:0]     queue_rd_q;
  logic [PROD_W-1:0]   prod_q;
  logic [SlotW-1:0]    match_idx_q;

  // Result register.
  logic                out_valid_q;
  status_e             status_q;
  logic [SIDX_W-1:0]   slot_used_q;
  logic [ID_W-1:0]     promoted_q;
  logic [COST_W-1:0]   total_q;

  // Lookup signals.
  logic                id_ok, sidx_ok;
  logic                free_any, match_any;
  logic [SlotW-1:0]    free_idx, match_idx;
  logic [SlotW-1:0]    rate_wa;
  logic [ReqW-1:0]     weight_addr;
  logic                queue_full, promote;
  logic                arrive_place, arrive_queue, rate_we, weight_we;
  status_e             look_status;
  logic [SlotW-1:0]    look_slot;
  logic [COST_W:0]     cost_sum;
  logic [COST_W-1:0]   cost_sat;

  // Capture the request on accept.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      kind_q <= kind_e'(kind_i);
      sidx_q <= slot_index_i;
      id_q   <= requester_id_i;
      val_q  <= load_value_i;
    end
  end

  // Range checks on the captured request.
  assign id_ok   = (id_q != '0) && (13'(id_q) <= 13'(REQUESTERS));
  assign sidx_ok = (8'(sidx_q) < 8'(SLOTS));
  assign rate_wa     = SlotW'(sidx_q);
  assign weight_addr = ReqW'(id_q - 7'd1);

  // Parallel compare over all slots, lowest index wins.
  always_comb begin
    free_any  = 1'b0;
    match_any = 1'b0;
    free_idx  = '0;
    match_idx = '0;
    for (int j = SLOTS - 1; j >= 0; j--) begin
      if (holder_q[j] == '0) begin
        free_any = 1'b1;
        free_idx = SlotW'(j);
      end
      if (holder_q[j] == id_q) begin
        match_any = 1'b1;
        match_idx = SlotW'(j);
      end
    end
  end

  // Outcome of the lookup for every request that ends there.
  assign queue_full   = (count_q == COUNT_W'(WAIT_DEPTH));
  assign arrive_place = (kind_q == KIND_ARRIVE) && id_ok && free_any;
  assign arrive_queue = (kind_q == KIND_ARRIVE) && id_ok && !free_any && !queue_full;
  assign rate_we      = cmd_i.look_emit && (kind_q == KIND_LOAD_RATE) && sidx_ok;
  assign weight_we    = cmd_i.look_emit && (kind_q == KIND_LOAD_WEIGHT) && id_ok;

  always_comb begin
    look_status = RES_NOT_FOUND;
    look_slot   = '0;
    priority if (kind_q == KIND_LOAD_RATE || kind_q == KIND_LOAD_WEIGHT) begin
      look_status = RES_LOADED;
    end else if (!id_ok) begin
      look_status = RES_NOT_FOUND;
    end else if (kind_q == KIND_ARRIVE) begin
      if (free_any) begin
        look_status = RES_PLACED;
        look_slot   = free_idx;
      end else if (queue_full) begin
        look_status = RES_FULL;
      end else begin
        look_status = RES_QUEUED;
      end
    end else begin
      look_status = RES_NOT_FOUND;
    end
  end

  // Status to the controller.
  assign stat_o.dep_hit  = (kind_q == KIND_DEPART) && id_ok && match_any;
  assign stat_o.out_room = !out_valid_q || !out_stall_i;

  // Rate memory: load writes, read at the matched slot.
  always_ff @(posedge clk_i) begin
    if (rate_we) begin
      rate_mem[rate_wa] <= val_q[RATE_W-1:0];
    end
    rate_rd_q <= rate_mem[match_idx];
  end

  // Weight memory: load writes, read at the requester.
  always_ff @(posedge clk_i) begin
    if (weight_we) begin
      weight_mem[weight_addr] <= val_q[WEIGHT_W-1:0];
    end
    weight_rd_q <= weight_mem[weight_addr];
  end

  // Wait queue memory: arrivals write at the tail, the head is read always.
  always_ff @(posedge clk_i) begin
    if (cmd_i.look_emit && arrive_queue) begin
      queue_mem[tail_q] <= id_q;
    end
    queue_rd_q <= queue_mem[head_q];
  end

  // Multiply stage and matched slot for the accumulate state.
  always_ff @(posedge clk_i) begin
    prod_q      <= PROD_W'(rate_rd_q) * PROD_W'(weight_rd_q);
    match_idx_q <= match_idx;
  end

  // Saturating accumulate.
  assign cost_sum = {1'b0, cost_q} + (COST_W + 1)'(prod_q);
  assign cost_sat = cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
  assign promote  = (count_q != '0);

  // Slot holders, queue pointers and the running cost.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < SLOTS; j++) begin
        holder_q[j] <= '0;
      end
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
      cost_q  <= '0;
    end else begin
      if (cmd_i.look_emit && arrive_place) begin
        holder_q[free_idx] <= id_q;
      end else if (cmd_i.acc_emit) begin
        holder_q[match_idx_q] <= promote ? queue_rd_q : '0;
      end
      if (cmd_i.look_emit && arrive_queue) begin
        tail_q  <= tail_q + 1'b1;
        count_q <= count_q + 1'b1;
      end else if (cmd_i.acc_emit && promote) begin
        head_q  <= head_q + 1'b1;
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.acc_emit) begin
        cost_q <= cost_sat;
      end
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.look_emit || cmd_i.acc_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.look_emit) begin
      status_q    <= look_status;
      slot_used_q <= SIDX_W'(look_slot);
      promoted_q  <= '0;
      total_q     <= cost_q;
    end else if (cmd_i.acc_emit) begin
      status_q    <= promote ? RES_PROMOTED : RES_FREED;
      slot_used_q <= SIDX_W'(match_idx_q);
      promoted_q  <= promote ? queue_rd_q : '0;
      total_q     <= cost_sat;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign slot_used_o   = slot_used_q;
  assign promoted_id_o = promoted_q;
  assign total_cost_o  = total_q;

  `SA_ASSERT_NEVER(a_queue_over, count_q > COUNT_W'(WAIT_DEPTH), "wait queue count overflow")
  `SA_ASSERT(a_queue_ring, (tail_q - head_q) == count_q[QUEUE_AW-1:0], "queue pointers disagree with count")
  `SA_ASSERT(a_acc_holder, cmd_i.acc_emit |-> holder_q[match_idx_q] == id_q, "freed slot not held by requester")

endmodule

/* design/slot_allocator_fifo_waitlist.sv */
// Top level of the slot allocator: controller plus datapath.
// Depends on salloc_pkg, salloc_ctrl and salloc_dp.
//
// Lowest-free-slot allocator with a 64-entry FIFO wait list and saturating
// 40-bit cost accounting. One request is worked on at a time and each gives
// exactly one result. A load or an arrival is captured on accept; the parallel
// slot compare and the state update follow in the lookup state. A departure
// that finds its slot also passes the multiply and accumulate states, since
// the rate and weight memories are read with a registered port and the
// product gets its own register before the saturating add. The result sits in
// an output register, so a waiting result does not hold up the next request
// until that next result is ready. Slot holders are flip-flops cleared by
// reset; there is no clearing pass.
module slot_allocator_fifo_waitlist import salloc_pkg::*; #(
  parameter int SLOTS      = DEF_SLOTS,
  parameter int REQUESTERS = DEF_REQUESTERS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [KIND_W-1:0]   kind_i,
  input  logic [SIDX_W-1:0]   slot_index_i,
  input  logic [ID_W-1:0]     requester_id_i,
  input  logic [LOAD_W-1:0]   load_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [SIDX_W-1:0]   slot_used_o,
  output logic [ID_W-1:0]     promoted_id_o,
  output logic [COST_W-1:0]   total_cost_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // Sequencer.
  salloc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Storage and arithmetic.
  salloc_dp #(
    .SLOTS      (SLOTS),
    .REQUESTERS (REQUESTERS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .kind_i         (kind_i),
    .slot_index_i   (slot_index_i),
    .requester_id_i (requester_id_i),
    .load_value_i   (load_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .slot_used_o    (slot_used_o),
    .promoted_id_o  (promoted_id_o),
    .total_cost_o   (total_cost_o)
  );

endmodule

/* verif/tb_slot_allocator_fifo_waitlist.sv */
// Self-checking testbench for the slot allocator with its FIFO wait list.
// Depends on salloc_pkg and the slot_allocator_fifo_waitlist RTL; needs no other file.
// A directed table, then random traffic, then charges at maximum rates and weights.
module tb_slot_allocator_fifo_waitlist import salloc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS      = DEF_SLOTS;
  localparam int REQUESTERS = DEF_REQUESTERS;
  localparam logic [COST_W-1:0] COST_FULL = '1;

  typedef struct packed {
    kind_e             kind;
    logic [SIDX_W-1:0] sidx;
    logic [ID_W-1:0]   id;
    logic [LOAD_W-1:0] val;
  } request_t;

  typedef struct packed {
    status_e           status;
    logic [SIDX_W-1:0] slot;
    logic [ID_W-1:0]   prom;
    logic [COST_W-1:0] cost;
  } outcome_t;

  // One table row: a request sent reps times, with an optional typed-in outcome.
  typedef struct {
    request_t req;
    int       reps;
    bit       typed;
    outcome_t want;
  } step_t;

  localparam logic [COST_W-1:0] C1 = 40'd16759809;  // 1023 * 16383

  step_t plan [19] = '{
    '{'{KIND_ARRIVE, 4'd0, 7'd0, 14'd0}, 1, 1'b1, '{RES_NOT_FOUND, 4'd0, 7'd0, 40'd0}},
    '{'{KIND_ARRIVE, 4'd15, 7'd127, 14'h3FFF}, 1, 1'b1, '{RES_NOT_FOUND, 4'd0, 7'd0, 40'd0}},
    '{'{KIND_DEPART, 4'd0, 7'd65, 14'd0}, 1, 1'b1, '{RES_NOT_FOUND, 4'd0, 7'd0, 40'd0}},
    '{'{KIND_DEPART, 4'd0, 7'd5, 14'd0}, 1, 1'b1, '{RES_NOT_FOUND, 4'd0, 7'd0, 40'd0}},
    '{'{KIND_LOAD_RATE, 4'd0, 7'd0, 14'h3FFF}, 1, 1'b1, '{RES_LOADED, 4'd0, 7'd0, 40'd0}},
    '{'{KIND_LOAD_RATE, 4'd15, 7'd127, 14'd1}, 1, 1'b1, '{RES_LOADED, 4'd0, 7'd0, 40'd0}},
    '{'{KIND_LOAD_WEIGHT, 4'd0, 7'd1, 14'h3FFF}, 1, 1'b1, '{RES_LOADED, 4'd0, 7'd0, 40'd0}},
    '{'{KIND_LOAD_WEIGHT, 4'd0, 7'd64, 14'h3FFF}, 1, 1'b1, '{RES_LOADED, 4'd0, 7'd0, 40'd0}},
    '{'{KIND_LOAD_WEIGHT, 4'd15, 7'd0, 14'd5}, 1, 1'b1, '{RES_LOADED, 4'd0, 7'd0, 40'd0}},
    '{'{KIND_LOAD_WEIGHT, 4'd0, 7'd127, 14'd7}, 1, 1'b1, '{RES_LOADED, 4'd0, 7'd0, 40'd0}},
    '{'{KIND_ARRIVE, 4'd0, 7'd1, 14'd0}, 1, 1'b1, '{RES_PLACED, 4'd0, 7'd0, 40'd0}},
    '{'{KIND_DEPART, 4'd0, 7'd1, 14'd0}, 1, 1'b1, '{RES_FREED, 4'd0, 7'd0, C1}},
    '{'{KIND_ARRIVE, 4'd0, 7'd64, 14'd0}, 16, 1'b0, '{RES_LOADED, 4'd0, 7'd0, 40'd0}},
    '{'{KIND_ARRIVE, 4'd0, 7'd1, 14'd0}, 64, 1'b0, '{RES_LOADED, 4'd0, 7'd0, 40'd0}},
    '{'{KIND_ARRIVE, 4'd0, 7'd2, 14'd0}, 1, 1'b1, '{RES_FULL, 4'd0, 7'd0, C1}},
    '{'{KIND_DEPART, 4'd0, 7'd64, 14'd0}, 1, 1'b1, '{RES_PROMOTED, 4'd0, 7'd1, 2 * C1}},
    '{'{KIND_DEPART, 4'd0, 7'd1, 14'd0}, 1, 1'b1, '{RES_PROMOTED, 4'd0, 7'd1, 3 * C1}},
    '{'{KIND_DEPART, 4'd0, 7'd2, 14'd0}, 1, 1'b1, '{RES_NOT_FOUND, 4'd0, 7'd0, 3 * C1}},
    '{'{KIND_ARRIVE, 4'd0, 7'd3, 14'd0}, 1, 1'b1, '{RES_QUEUED, 4'd0, 7'd0, 3 * C1}}
  };

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [KIND_W-1:0]   kind_i = '0;
  logic [SIDX_W-1:0]   slot_index_i = '0;
  logic [ID_W-1:0]     requester_id_i = '0;
  logic [LOAD_W-1:0]   load_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [SIDX_W-1:0]   slot_used_o;
  logic [ID_W-1:0]     promoted_id_o;
  logic [COST_W-1:0]   total_cost_o;

  // Shadow state of the allocator, advanced once per accepted request.
  logic [ID_W-1:0]     holder [SLOTS];
  logic [RATE_W-1:0]   rate_tbl [SLOTS];
  bit                  rate_set [SLOTS];
  logic [WEIGHT_W-1:0] weight_tbl [REQUESTERS];
  bit                  weight_set [REQUESTERS];
  logic [ID_W-1:0]     waitlist [$];
  logic [COST_W-1:0]   cost_acc;

  outcome_t pending_results [$];
  int       mismatches;
  int       results_seen;
  bit       sender_gaps;

  slot_allocator_fifo_waitlist dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .slot_index_i   (slot_index_i),
    .requester_id_i (requester_id_i),
    .load_value_i   (load_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .slot_used_o    (slot_used_o),
    .promoted_id_o  (promoted_id_o),
    .total_cost_o   (total_cost_o)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic bit id_in_range(logic [ID_W-1:0] id);
    return id >= 1 && id <= REQUESTERS;
  endfunction

  // Lowest slot whose holder equals id; an id of zero finds the lowest free slot.
  function automatic int find_slot(logic [ID_W-1:0] id);
    for (int j = 0; j < SLOTS; j++) begin
      if (holder[j] == id) return j;
    end
    return -1;
  endfunction

  // Advances the shadow state by one request and returns the outcome it must give.
  function automatic outcome_t apply_request(request_t r);
    outcome_t            o;
    int                  hit;
    logic [PROD_W-1:0]   prod;
    logic [COST_W:0]     sum;
    o = '{RES_LOADED, 4'd0, 7'd0, 40'd0};
    case (r.kind)
      KIND_LOAD_RATE: begin
        if (r.sidx < SLOTS) begin
          rate_tbl[r.sidx] = r.val[RATE_W-1:0];
          rate_set[r.sidx] = 1'b1;
        end
      end
      KIND_LOAD_WEIGHT: begin
        if (id_in_range(r.id)) begin
          weight_tbl[r.id - 1] = r.val;
          weight_set[r.id - 1] = 1'b1;
        end
      end
      KIND_ARRIVE: begin
        if (!id_in_range(r.id)) begin
          o.status = RES_NOT_FOUND;
        end else begin
          hit = find_slot('0);
          if (hit >= 0) begin
            holder[hit] = r.id;
            o.status = RES_PLACED;
            o.slot = hit[SIDX_W-1:0];
          end else if (waitlist.size() >= WAIT_DEPTH) begin
            o.status = RES_FULL;
          end else begin
            waitlist.push_back(r.id);
            o.status = RES_QUEUED;
          end
        end
      end
      default: begin
        hit = id_in_range(r.id) ? find_slot(r.id) : -1;
        if (hit < 0) begin
          o.status = RES_NOT_FOUND;
        end else begin
          // Charge rate times weight, clamped at the top of the 40-bit range.
          prod = rate_tbl[hit] * weight_tbl[r.id - 1];
          sum = cost_acc + prod;
          cost_acc = sum[COST_W] ? COST_FULL : sum[COST_W-1:0];
          holder[hit] = '0;
          o.slot = hit[SIDX_W-1:0];
          o.status = RES_FREED;
          if (waitlist.size() > 0) begin
            holder[hit] = waitlist.pop_front();
            o.status = RES_PROMOTED;
            o.prom = holder[hit];
          end
        end
      end
    endcase
    o.cost = cost_acc;
    return o;
  endfunction

  // Mostly valid requesters, now and then an id outside the range.
  function automatic logic [ID_W-1:0] random_id();
    if ($urandom_range(19) == 0) begin
      return ($urandom_range(1) == 0) ? 7'd0 : 7'($urandom_range(65, 127));
    end
    return 7'($urandom_range(1, REQUESTERS));
  endfunction

  task automatic log_mismatch(string what, outcome_t want, outcome_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s:", $realtime, what);
      $display("  expected status=%0d slot=%0d prom=%0d cost=%0d",
               want.status, want.slot, want.prom, want.cost);
      $display("  got      status=%0d slot=%0d prom=%0d cost=%0d",
               got.status, got.slot, got.prom, got.cost);
    end
  endtask

  // Presents one request from a falling edge and returns at the falling edge after
  // it was taken. Valid is only lowered for a random gap.
  task automatic send_request(request_t r, bit typed, outcome_t want);
    outcome_t model;
    if (sender_gaps && $urandom_range(99) < 11) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= r.kind;
    slot_index_i   <= r.sidx;
    requester_id_i <= r.id;
    load_value_i   <= r.val;
    do @(posedge clk_i); while (in_stall_o);
    model = apply_request(r);
    pending_results.push_back(typed ? want : model);
    @(negedge clk_i);
  endtask

  // Holds off the sender until every outstanding request has been answered.
  task automatic idle_until_drained();
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    @(negedge clk_i);
  endtask

  // Receiver stalls at random, except for a quiet stretch of results.
  always @(negedge clk_i) begin
    out_stall_i <= !(results_seen >= 600 && results_seen < 800) && ($urandom_range(99) < 11);
  end

  // Each accepted result is checked against the oldest pending outcome.
  always @(posedge clk_i) begin : check_results
    outcome_t want;
    outcome_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      got = '{status_e'(status_o), slot_used_o, promoted_id_o, total_cost_o};
      if (pending_results.size() == 0) begin
        log_mismatch("result with no request outstanding", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status || slot_used_o !== want.slot ||
            promoted_id_o !== want.prom || total_cost_o !== want.cost) begin
          log_mismatch("result mismatch", want, got);
        end
      end
    end
  end

  initial begin : stimulus
    request_t r;
    outcome_t none;
    int       pick;
    int       arrive_pct;
    int       j;
    int       busy;

    none = '{RES_LOADED, 4'd0, 7'd0, 40'd0};
    foreach (holder[k]) begin
      holder[k] = '0;
      rate_set[k] = 1'b0;
    end
    foreach (weight_set[k]) weight_set[k] = 1'b0;
    cost_acc = '0;
    mismatches = 0;
    results_seen = 0;
    sender_gaps = 1'b1;
    arrive_pct = 50;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table: bad ids, absent requester, extreme loads, full queue, promotion.
    foreach (plan[s]) begin
      repeat (plan[s].reps) send_request(plan[s].req, plan[s].typed, plan[s].want);
    end
    idle_until_drained();

    // Random traffic with phases that lean toward arrivals or toward departures.
    for (int n = 0; n < 950; n++) begin
      if (n % 100 == 0) arrive_pct = $urandom_range(15, 85);
      sender_gaps = !(n >= 500 && n < 700);
      if (n == 900) idle_until_drained();
      pick = $urandom_range(99);
      r.sidx = 4'($urandom_range(15));
      r.id = 7'($urandom_range(127));
      r.val = 14'($urandom_range(16383));
      if (pick < 10) begin
        r.kind = (pick % 2 == 0) ? KIND_LOAD_RATE : KIND_LOAD_WEIGHT;
        if (r.kind == KIND_LOAD_WEIGHT) r.id = random_id();
      end else if (pick < 10 + arrive_pct * 90 / 100) begin
        r.kind = KIND_ARRIVE;
        r.id = random_id();
      end else begin
        r.kind = KIND_DEPART;
        r.id = random_id();
        j = $urandom_range(SLOTS - 1);
        if ($urandom_range(9) < 8 && holder[j] != '0) r.id = holder[j];
        // A departure may only charge a rate and a weight that were loaded.
        if (id_in_range(r.id)) begin
          j = find_slot(r.id);
          if (j >= 0 && !weight_set[r.id - 1]) begin
            r.kind = KIND_LOAD_WEIGHT;
          end else if (j >= 0 && !rate_set[j]) begin
            r.kind = KIND_LOAD_RATE;
            r.sidx = j[SIDX_W-1:0];
          end
        end
      end
      send_request(r, 1'b0, none);
    end

    // Maximum rates and weights, then release every slot at the largest charge.
    sender_gaps = 1'b0;
    for (int k = 0; k < SLOTS; k++) begin
      send_request('{KIND_LOAD_RATE, 4'(k), 7'd0, 14'h3FFF}, 1'b0, none);
    end
    for (int k = 1; k <= REQUESTERS; k++) begin
      send_request('{KIND_LOAD_WEIGHT, 4'd0, 7'(k), 14'h3FFF}, 1'b0, none);
    end
    do begin
      busy = -1;
      foreach (holder[k]) if (holder[k] != '0 && busy < 0) busy = k;
      if (busy >= 0) send_request('{KIND_DEPART, 4'd0, holder[busy], 14'd0}, 1'b0, none);
    end while (busy >= 0);
    in_valid_i <= 1'b0;

    // Let the last results arrive, then watch a few more cycles for strays.
    for (int n = 0; n < 2000 && pending_results.size() != 0; n++) @(posedge clk_i);
    while (pending_results.size() != 0) begin
      log_mismatch("result never arrived", pending_results.pop_front(), '0);
    end
    repeat (8) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb_slot_allocator_fifo_waitlist passed");
    end else begin
      $display("tb_slot_allocator_fifo_waitlist failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #40_000_000;
    $display("tb_slot_allocator_fifo_waitlist failed");
    $finish;
  end

endmodule
